>>> design/stars_pkg.sv
package stars_pkg;

    // The widest node index: twice the largest supported tree size.
    localparam int IDX_W = 22;
    localparam int SUM_W = 64;

    // Operation codes of an input item.
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // One walk token, handed from a tree level to its parent level.
    typedef struct packed {
        logic             vld;
        logic             op;
        logic             en;
        logic [IDX_W-1:0] l;
        logic [IDX_W-1:0] r;
        logic [SUM_W-1:0] acc;
        logic [SUM_W-1:0] dlt;
    } tok_t;

    // Clearing sweep control, broadcast to every level.
    typedef struct packed {
        logic             act;
        logic [IDX_W-1:0] addr;
    } clr_t;

endpackage

>>> design/segment_tree_add_range_sum.sv
// Segment tree with point add and half-open range sum over LEAVES leaves.
// The tree is a chain of cells, one per level from the leaves up to the
// root; each cell keeps that level's 64-bit node sums in its own memory.
// An item walks the chain bottom up, going in each cell through a read, a
// first add or leaf update and a second add, and only one item is in the
// chain at a time; a query whose result finds the output register still
// full holds off the next item until the receiver takes it. An add item
// (operation 0) adds the sign-extended delta along one root path and gives
// no result; a query item (operation 1) returns the wrapping sum of the
// leaves from range_low up to but not including range_high, with both
// bounds clamped to LEAVES, and zero for an empty range. After reset the
// block runs a clearing pass over one address per leaf of the tree rounded
// up to a power of two, in every level at once, with in_ready low. A
// finished result waits in the output register while the next item is
// taken.
module segment_tree_add_range_sum
    import stars_pkg::*;
#(
    parameter int LEAVES = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               operation,
    input  logic [9:0]         position,
    input  logic signed [31:0] delta,
    input  logic [10:0]        range_low,
    input  logic [10:0]        range_high,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [63:0] range_sum
);

    localparam int LOG  = $clog2(LEAVES);
    localparam int SIZE = 1 << LOG;

    logic             clearing_reg;
    logic [LOG-1:0]   clr_cnt_reg;
    logic             busy_reg;
    logic             pend_reg;
    logic [SUM_W-1:0] pend_sum_reg;
    logic             out_valid_reg;
    logic [SUM_W-1:0] out_sum_reg;
    tok_t             tok0_reg;
    tok_t             tok0_next;
    clr_t             clr;
    tok_t             links [LOG+2];

    logic [31:0]      lo_w, hi_w, lo_c, hi_c, pos_w;
    logic             accept;

    assign accept   = in_valid && in_ready;
    assign in_ready = !busy_reg && !clearing_reg;

    assign clr.act  = clearing_reg;
    assign clr.addr = IDX_W'(clr_cnt_reg);

    // Bounds past the last leaf are clamped to LEAVES.
    assign lo_w  = 32'(range_low);
    assign hi_w  = 32'(range_high);
    assign pos_w = 32'(position);
    assign lo_c  = (lo_w > 32'(LEAVES)) ? 32'(LEAVES) : lo_w;
    assign hi_c  = (hi_w > 32'(LEAVES)) ? 32'(LEAVES) : hi_w;

    always_comb
    begin
        tok0_next     = '0;
        tok0_next.vld = 1'b1;
        tok0_next.op  = operation;
        tok0_next.dlt = {{32{delta[31]}}, delta};
        if (operation == OP_QUERY)
        begin
            tok0_next.l = IDX_W'(lo_c) + IDX_W'(SIZE);
            tok0_next.r = IDX_W'(hi_c) + IDX_W'(SIZE);
        end
        else
        begin
            // An add to a leaf beyond LEAVES changes nothing.
            tok0_next.en = pos_w < 32'(LEAVES);
            tok0_next.l  = IDX_W'(pos_w) + IDX_W'(SIZE);
        end
    end

    assign links[0] = tok0_reg;

    // Cell i holds tree level LOG - i: leaves first, root last.
    genvar gi;
    generate
        for (gi = 0; gi <= LOG; gi++)
        begin : g_level
            stars_cell #(
                .LEVEL(LOG - gi)
            ) u_cell (
                .clk  (clk),
                .rst_n(rst_n),
                .clr  (clr),
                .tin  (links[gi]),
                .tout (links[gi+1])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            busy_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            pend_sum_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_sum_reg   <= '0;
            tok0_reg      <= '0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + LOG'(1);
                if (&clr_cnt_reg)
                begin
                    clearing_reg <= 1'b0;
                end
            end

            if (accept)
            begin
                tok0_reg <= tok0_next;
                busy_reg <= 1'b1;
            end
            else
            begin
                tok0_reg.vld <= 1'b0;
            end

            // The root cell hands back the finished walk.
            if (links[LOG+1].vld)
            begin
                if (links[LOG+1].op == OP_QUERY)
                begin
                    pend_reg     <= 1'b1;
                    pend_sum_reg <= links[LOG+1].acc;
                end
                else
                begin
                    busy_reg <= 1'b0;
                end
            end

            if (pend_reg && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
                out_sum_reg   <= pend_sum_reg;
                pend_reg      <= 1'b0;
                busy_reg      <= 1'b0;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign range_sum = out_sum_reg;

endmodule

>>> design/stars_cell.sv
module stars_cell
    import stars_pkg::*;
#(
    parameter int LEVEL = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  clr_t clr,
    input  tok_t tin,
    output tok_t tout
);

    // A level of depth LEVEL holds 2**LEVEL nodes, addressed by the low bits
    // of the absolute node index.
    localparam int AW = (LEVEL > 0) ? LEVEL : 1;

    logic [SUM_W-1:0] mem [2**AW];

    logic             ph1_reg, ph2_reg;
    tok_t             hold_reg;
    logic [SUM_W-1:0] rd0_reg, rd1_reg;
    logic [SUM_W-1:0] acc_reg;
    tok_t             tout_reg;

    logic [IDX_W-1:0] rm1;
    logic             lt, lodd, rodd;
    logic [IDX_W-1:0] l_inc, r_dec;
    tok_t             tout_next;

    assign rm1  = tin.r - IDX_W'(1);
    assign lt   = hold_reg.l < hold_reg.r;
    assign lodd = hold_reg.l[0];
    assign rodd = hold_reg.r[0];

    assign l_inc = (hold_reg.op == OP_QUERY)
                 ? hold_reg.l + {{(IDX_W-1){1'b0}}, lodd} : hold_reg.l;
    assign r_dec = hold_reg.r - {{(IDX_W-1){1'b0}}, rodd};

    always_comb
    begin
        tout_next     = hold_reg;
        tout_next.vld = 1'b1;
        tout_next.l   = l_inc >> 1;
        tout_next.r   = r_dec >> 1;
        tout_next.acc = acc_reg
                      + (((hold_reg.op == OP_QUERY) && lt && rodd) ? rd1_reg : '0);
    end

    // Node storage: registered reads, one write port shared by the
    // clearing sweep and the add update.
    always_ff @(posedge clk)
    begin
        rd0_reg <= mem[tin.l[AW-1:0]];
        rd1_reg <= mem[rm1[AW-1:0]];
        if (clr.act)
        begin
            mem[clr.addr[AW-1:0]] <= '0;
        end
        else if (ph1_reg && (hold_reg.op == OP_ADD) && hold_reg.en)
        begin
            mem[hold_reg.l[AW-1:0]] <= rd0_reg + hold_reg.dlt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph1_reg  <= 1'b0;
            ph2_reg  <= 1'b0;
            hold_reg <= '0;
            acc_reg  <= '0;
            tout_reg <= '0;
        end
        else
        begin
            ph1_reg <= tin.vld;
            ph2_reg <= ph1_reg;
            if (tin.vld)
            begin
                hold_reg <= tin;
            end
            if (ph1_reg)
            begin
                acc_reg <= hold_reg.acc
                         + (((hold_reg.op == OP_QUERY) && lt && lodd) ? rd0_reg : '0);
            end
            if (ph2_reg)
            begin
                tout_reg <= tout_next;
            end
            else
            begin
                tout_reg.vld <= 1'b0;
            end
        end
    end

    assign tout = tout_reg;

endmodule
